@@ src/lcfm_pkg.sv @@
package lcfm_pkg;

	localparam int NUM_ENTRIES     = 16;
	localparam int NUM_WIDTH_SLOTS = 8;
	localparam int ENTRY_W         = 4;
	localparam int SLOT_W          = 3;
	localparam int ADDR_W          = ENTRY_W + SLOT_W;
	localparam int LIMIT_W         = 5;
	localparam int WCOUNT_W        = 4;
	localparam int WIDTH_W         = 8;
	localparam int BITS_W          = 32;
	localparam int COST_W          = 16;
	localparam int WANT_W          = 32;
	localparam int PROD_W          = WANT_W + WIDTH_W;

	localparam logic [COST_W-1:0]  COST_NONE   = 16'hffff;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(NUM_ENTRIES);
	localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(NUM_WIDTH_SLOTS - 1);

	typedef logic [1:0] op_t;
	localparam op_t OP_HEADER = 2'd0;
	localparam op_t OP_WIDTH  = 2'd1;
	localparam op_t OP_QUERY  = 2'd2;

	localparam logic [2:0] REG_ENTRIES_IN_USE = 3'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic               hdr_we;
		logic               wid_we;
		logic               capture;
		logic               issue;
		logic [ENTRY_W-1:0] rd_entry;
		logic [SLOT_W-1:0]  rd_slot;
		logic               publish;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} status_t;

endpackage

@@ src/lcfm_ctrl.sv @@
module lcfm_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  lcfm_pkg::op_t            op,
	input  logic [4:0]               entries_in_use,
	input  lcfm_pkg::status_t        status,
	output lcfm_pkg::cmd_t           cmd,
	output logic                     busy
);
	import lcfm_pkg::*;

	state_t               state_q, state_d;
	logic [ADDR_W-1:0]    idx_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [LIMIT_W-1:0]   limit_d;
	logic                 last_issue;

	assign limit_d = (entries_in_use > LIMIT_MAX) ? LIMIT_MAX : entries_in_use;
	assign last_issue = (idx_q[SLOT_W-1:0] == SLOT_LAST) &&
		(({1'b0, idx_q[ADDR_W-1:SLOT_W]} + 5'd1) == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			limit_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				idx_q   <= '0;
				limit_q <= limit_d;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 7'd1;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.rd_entry = idx_q[ADDR_W-1:SLOT_W];
		cmd.rd_slot  = idx_q[SLOT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.hdr_we = (op == OP_HEADER);
					cmd.wid_we = (op == OP_WIDTH);
					if (op == OP_QUERY) begin
						cmd.capture = 1'b1;
						state_d = (limit_d == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (last_issue)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// The best-so-far registers are final once the last slot has left the pipe.
				if (!status.pipe_busy) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ src/lcfm_dp.sv @@
module lcfm_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  lcfm_pkg::cmd_t     cmd,
	output lcfm_pkg::status_t  status,
	input  logic [3:0]         entry_index,
	input  logic [2:0]         slot_index,
	input  logic [7:0]         width_value,
	input  logic [31:0]        total_bits,
	input  logic [15:0]        entry_cost,
	input  logic [3:0]         width_count,
	input  logic [31:0]        want_width,
	input  logic [31:0]        want_depth,
	output logic               done,
	output logic               found,
	output logic [3:0]         best_entry,
	output logic [15:0]        min_cost
);
	import lcfm_pkg::*;

	logic [BITS_W-1:0]   bits_mem  [NUM_ENTRIES];
	logic [COST_W-1:0]   price_mem [NUM_ENTRIES];
	logic [WCOUNT_W-1:0] cnt_mem   [NUM_ENTRIES];
	logic [WIDTH_W-1:0]  wid_mem   [NUM_ENTRIES*NUM_WIDTH_SLOTS];

	logic [WANT_W-1:0]   want_w_q, want_d_q;
	logic                want_zero_q;

	logic                valid_s1, valid_s2;
	logic [WIDTH_W-1:0]  width_s1;
	logic [BITS_W-1:0]   bits_s1, bits_s2;
	logic [COST_W-1:0]   price_s1, price_s2;
	logic [WCOUNT_W-1:0] cnt_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [ENTRY_W-1:0]  entry_s1, entry_s2;
	logic                last_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic                okw_s2;

	logic                fit_q, hit_q;
	logic [COST_W-1:0]   cost_q;
	logic [ENTRY_W-1:0]  entry_q;
	logic                slot_hit, entry_fit;

	always_ff @(posedge clk) begin
		if (cmd.hdr_we) begin
			bits_mem[entry_index]  <= total_bits;
			price_mem[entry_index] <= entry_cost;
			cnt_mem[entry_index]   <= width_count;
		end
		if (cmd.wid_we)
			wid_mem[{entry_index, slot_index}] <= width_value;
		if (cmd.capture) begin
			want_w_q    <= want_width;
			want_d_q    <= want_depth;
			want_zero_q <= (want_width == '0) || (want_depth == '0);
		end
		width_s1 <= wid_mem[{cmd.rd_entry, cmd.rd_slot}];
		bits_s1  <= bits_mem[cmd.rd_entry];
		price_s1 <= price_mem[cmd.rd_entry];
		cnt_s1   <= cnt_mem[cmd.rd_entry];
		slot_s1  <= cmd.rd_slot;
		entry_s1 <= cmd.rd_entry;
		// depth <= bits / width is the same as depth * width <= bits for a non-zero width.
		prod_s2  <= {8'b0, want_d_q} * {32'b0, width_s1};
		okw_s2   <= !want_zero_q && (width_s1 != '0) &&
			({24'b0, width_s1} >= want_w_q) && ({1'b0, slot_s1} < cnt_s1);
		bits_s2  <= bits_s1;
		price_s2 <= price_s1;
		entry_s2 <= entry_s1;
		last_s2  <= (slot_s1 == SLOT_LAST);
	end

	assign slot_hit  = okw_s2 && (prod_s2 <= {8'b0, bits_s2});
	assign entry_fit = fit_q || slot_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			fit_q      <= 1'b0;
			hit_q      <= 1'b0;
			cost_q     <= COST_NONE;
			entry_q    <= '0;
			done       <= 1'b0;
			found      <= 1'b0;
			best_entry <= '0;
			min_cost   <= COST_NONE;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			done     <= cmd.publish;
			if (cmd.capture) begin
				fit_q   <= 1'b0;
				hit_q   <= 1'b0;
				cost_q  <= COST_NONE;
				entry_q <= '0;
			end else if (valid_s2) begin
				if (last_s2) begin
					fit_q <= 1'b0;
					// Strictly lower only, so the earliest entry keeps a tie.
					if (entry_fit && (price_s2 < cost_q)) begin
						hit_q   <= 1'b1;
						cost_q  <= price_s2;
						entry_q <= entry_s2;
					end
				end else begin
					fit_q <= entry_fit;
				end
			end
			if (cmd.publish) begin
				found      <= hit_q;
				best_entry <= entry_q;
				min_cost   <= cost_q;
			end
		end
	end

	assign status.pipe_busy = valid_s1 || valid_s2;

endmodule

@@ src/lowest_cost_fit_matcher.sv @@
// Load transactions (header or width slot) complete at the accepting edge; busy stays low.
// A query scans entries_in_use entries (at most 16) times 8 width slots, one slot per cycle
// through a three-stage read, multiply and compare pipe, and the result is then published with done.
// busy falls as done rises, so the next query is accepted at the edge that takes the result.
// The receiver cannot stall: found, best_entry and min_cost are valid only while done is high.
// arst_n clears control state and entries_in_use; the table is undefined until loaded.
module lowest_cost_fit_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [3:0]  entry_index,
	input  logic [2:0]  slot_index,
	input  logic [7:0]  width_value,
	input  logic [31:0] total_bits,
	input  logic [15:0] entry_cost,
	input  logic [3:0]  width_count,
	input  logic [31:0] want_width,
	input  logic [31:0] want_depth,
	output logic        done,
	output logic        found,
	output logic [3:0]  best_entry,
	output logic [15:0] min_cost
);
	import lcfm_pkg::*;

	logic [LIMIT_W-1:0] entries_in_use_q;
	cmd_t               cmd;
	status_t            status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (psel && penable && pwrite && (paddr == REG_ENTRIES_IN_USE)) begin
			entries_in_use_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata = (paddr == REG_ENTRIES_IN_USE) ? {27'b0, entries_in_use_q} : '0;

	lcfm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.op             (op),
		.entries_in_use (entries_in_use_q),
		.status         (status),
		.cmd            (cmd),
		.busy           (busy)
	);

	lcfm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.entry_index (entry_index),
		.slot_index  (slot_index),
		.width_value (width_value),
		.total_bits  (total_bits),
		.entry_cost  (entry_cost),
		.width_count (width_count),
		.want_width  (want_width),
		.want_depth  (want_depth),
		.done        (done),
		.found       (found),
		.best_entry  (best_entry),
		.min_cost    (min_cost)
	);

endmodule

@@ src/lcfm_checker.sv @@
module lcfm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic        done,
	input  logic        found,
	input  logic [3:0]  best_entry,
	input  logic [15:0] min_cost
);
	import lcfm_pkg::*;

	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_QUERY) |=> busy)
		else $error("query transaction did not make the block busy");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op != OP_QUERY) |=> !busy && !done)
		else $error("load transaction made the block busy or produced a result");

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result appeared without a finished query");

	a_not_found_values: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> (min_cost == COST_NONE) && (best_entry == '0))
		else $error("not-found result carries an entry or a cost");

	a_found_cost: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> (min_cost != COST_NONE))
		else $error("found result carries the reserved cost");

endmodule

bind lowest_cost_fit_matcher lcfm_checker u_lcfm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.op         (op),
	.done       (done),
	.found      (found),
	.best_entry (best_entry),
	.min_cost   (min_cost)
);
